[rtl/rnsc_pkg.sv]
// ----------------------------------------------------------------------------
// rnsc_pkg: shared types and constants
// Request and result formats, epsilon default and sequencer state codes.
// ----------------------------------------------------------------------------
package rnsc_pkg;

    localparam int unsigned MaxLenDefault = 8192;
    localparam logic [31:0] EpsilonReset  = 32'd4295;
    localparam logic [31:0] InvRmsReset   = 32'h0010_0000;
    localparam logic [31:0] InvRmsMax     = 32'h7FFF_FFFF;
    localparam int unsigned QueueDepth    = 2;

    localparam logic OpAccumulate = 1'b0;
    localparam logic OpNormalize  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] sample;
        logic [31:0] weight;
        logic        weight_present;
        logic        is_last;
    } req_t;

    typedef struct packed {
        logic [31:0] normalized;
        logic        saturated;
    } res_t;

    // classified request as held in the queue
    typedef struct packed {
        logic        is_norm;
        logic        is_last;
        logic        neg;
        logic [31:0] mag;
        logic [31:0] wmag;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_SQ,
        ST_ACC_ADD,
        ST_DIV,
        ST_EPS,
        ST_ROOT_SQ,
        ST_ROOT_MUL,
        ST_ROOT_CMP,
        ST_NRM_P,
        ST_NRM_M0,
        ST_NRM_M1,
        ST_NRM_OUT
    } state_t;

endpackage

[rtl/rnsc_front.sv]
// ----------------------------------------------------------------------------
// rnsc_front: request intake
// Takes a request, forms sign and magnitudes, and pushes it into a queue.
// ----------------------------------------------------------------------------
module rnsc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rnsc_pkg::req_t    req,
    output logic              busy,
    input  logic              pop,
    output logic              job_valid,
    output rnsc_pkg::job_t    job
);
    localparam int unsigned PtrW = $clog2(rnsc_pkg::QueueDepth);

    rnsc_pkg::job_t           mem_reg [rnsc_pkg::QueueDepth];
    logic [PtrW-1:0]          wr_reg, wr_next, rd_reg, rd_next;
    logic [PtrW:0]            cnt_reg, cnt_next;
    logic                     push;
    rnsc_pkg::job_t           incoming;
    logic [31:0]              smag, wmag;
    logic                     sneg, wneg;

    assign busy      = (cnt_reg == PtrW'(0) + (PtrW+1)'(rnsc_pkg::QueueDepth));
    assign push      = start && !busy;
    assign job_valid = (cnt_reg != '0);
    assign job       = mem_reg[rd_reg];

    always_comb
    begin
        sneg = req.sample[31];
        smag = sneg ? (32'd0 - req.sample) : req.sample;
        wneg = req.weight_present & req.weight[31];
        if (req.weight_present)
        begin
            wmag = wneg ? (32'd0 - req.weight) : req.weight;
        end
        else
        begin
            wmag = 32'h0001_0000;
        end
        incoming.is_norm = (req.opcode == rnsc_pkg::OpNormalize);
        incoming.is_last = req.is_last;
        incoming.neg     = sneg ^ wneg;
        incoming.mag     = smag;
        incoming.wmag    = wmag;
    end

    always_comb
    begin
        wr_next  = push ? PtrW'(wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? PtrW'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PtrW+1)'(rnsc_pkg::QueueDepth))
        else $error("queue overfilled");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> job_valid)
        else $error("pop from empty queue");
    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (PtrW+1)'(rnsc_pkg::QueueDepth)) |-> busy)
        else $error("full queue not reported busy");
endmodule

[rtl/rnsc_divider.sv]
// ----------------------------------------------------------------------------
// rnsc_divider: 64 by 14 bit restoring divider
// One quotient bit per cycle; sum of squares over element count.
// ----------------------------------------------------------------------------
module rnsc_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [13:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] q_reg, q_next;
    logic [14:0] r_reg, r_next;
    logic [6:0]  n_reg, n_next;
    logic        run_reg, run_next;
    logic [13:0] d_reg, d_next;
    logic [14:0] trial;

    assign quotient = q_reg;
    assign done     = run_reg && (n_reg == 7'd0);

    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        n_next   = n_reg;
        run_next = run_reg;
        d_next   = d_reg;
        trial    = {r_reg[13:0], q_reg[63]};
        if (go)
        begin
            q_next   = dividend;
            r_next   = '0;
            n_next   = 7'd64;
            run_next = 1'b1;
            d_next   = divisor;
        end
        else if (run_reg)
        begin
            if (n_reg == 7'd0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                // advance one quotient bit
                if (trial >= {1'b0, d_reg})
                begin
                    r_next = trial - {1'b0, d_reg};
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    r_next = trial;
                    q_next = {q_reg[62:0], 1'b0};
                end
                n_next = n_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            n_reg   <= n_next;
            run_reg <= run_next;
        end
    end
endmodule

[rtl/rnsc_back.sv]
// ----------------------------------------------------------------------------
// rnsc_back: execution sequencer
// Accumulates squares, forms the inverse root and scales samples.
// ----------------------------------------------------------------------------
module rnsc_back #(
    parameter int unsigned MAX_LEN = rnsc_pkg::MaxLenDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       epsilon,
    input  logic              job_valid,
    input  rnsc_pkg::job_t    job,
    output logic              pop,
    output logic              idle,
    output logic              res_valid,
    output rnsc_pkg::res_t    res
);
    rnsc_pkg::state_t st_reg, st_next;
    rnsc_pkg::job_t   job_reg;
    logic [63:0]  sum_reg, sum_next;
    logic [13:0]  cnt_reg, cnt_next;
    logic [31:0]  inv_reg, inv_next;
    logic         clip_reg, clip_next;
    logic [63:0]  a_reg, a_next;      // square, product or mean
    logic [63:0]  m_reg, m_next;      // mean square plus epsilon
    logic [31:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [31:0]  mid_reg, mid_next;
    logic [63:0]  sq_reg, sq_next;
    logic [127:0] t_reg, t_next;      // wide partial product
    logic [1:0]   k_reg, k_next;      // partial product index
    logic         div_go, div_done;
    logic [63:0]  quot;
    logic [64:0]  s65;
    logic [31:0]  mpart;
    logic [63:0]  pp;
    logic [64:0]  rnd;
    logic [32:0]  lim;
    logic         clip_o;
    logic [31:0]  qv;

    // start the division on the updated sum and count of the closing element
    rnsc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (sum_next),
        .divisor  ((cnt_next == 14'd0) ? 14'd1 : cnt_next),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
        end
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            rnsc_pkg::ST_IDLE:     if (job_valid) st_next = job.is_norm ?
                                       rnsc_pkg::ST_NRM_P : rnsc_pkg::ST_ACC_SQ;
            rnsc_pkg::ST_ACC_SQ:   st_next = rnsc_pkg::ST_ACC_ADD;
            rnsc_pkg::ST_ACC_ADD:  st_next = job_reg.is_last ? rnsc_pkg::ST_DIV
                                                             : rnsc_pkg::ST_IDLE;
            rnsc_pkg::ST_DIV:      if (div_done) st_next = rnsc_pkg::ST_EPS;
            rnsc_pkg::ST_EPS:      st_next = rnsc_pkg::ST_ROOT_SQ;
            rnsc_pkg::ST_ROOT_SQ:  st_next = rnsc_pkg::ST_ROOT_MUL;
            rnsc_pkg::ST_ROOT_MUL: if (k_reg == 2'd3) st_next = rnsc_pkg::ST_ROOT_CMP;
            rnsc_pkg::ST_ROOT_CMP: st_next = (hi_next - lo_next > 32'd1) ?
                                             rnsc_pkg::ST_ROOT_SQ : rnsc_pkg::ST_IDLE;
            rnsc_pkg::ST_NRM_P:    st_next = rnsc_pkg::ST_NRM_M0;
            rnsc_pkg::ST_NRM_M0:   st_next = rnsc_pkg::ST_NRM_M1;
            rnsc_pkg::ST_NRM_M1:   st_next = rnsc_pkg::ST_NRM_OUT;
            rnsc_pkg::ST_NRM_OUT:  st_next = rnsc_pkg::ST_IDLE;
            default:               st_next = rnsc_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        inv_next  = inv_reg;
        clip_next = clip_reg;
        a_next    = a_reg;
        m_next    = m_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        mid_next  = mid_reg;
        sq_next   = sq_reg;
        t_next    = t_reg;
        k_next    = k_reg;
        pop       = 1'b0;
        div_go    = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        s65       = '0;
        mpart     = '0;
        pp        = '0;
        rnd       = '0;
        lim       = '0;
        clip_o    = 1'b0;
        qv        = '0;
        idle      = (st_reg == rnsc_pkg::ST_IDLE) && !job_valid;
        case (st_reg)
            rnsc_pkg::ST_IDLE:
            begin
                pop = job_valid;
            end
            rnsc_pkg::ST_ACC_SQ:
            begin
                a_next = {32'd0, job_reg.mag} * {32'd0, job_reg.mag};
            end
            rnsc_pkg::ST_ACC_ADD:
            begin
                if (cnt_reg == 14'd0) clip_next = 1'b0;
                s65 = {1'b0, sum_reg} + {1'b0, a_reg};
                if (s65[64])
                begin
                    sum_next  = '1;
                    clip_next = 1'b1;
                end
                else
                begin
                    sum_next = s65[63:0];
                end
                if (cnt_reg >= 14'(MAX_LEN))
                begin
                    cnt_next  = 14'(MAX_LEN);
                    clip_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 14'd1;
                end
                div_go = job_reg.is_last;
            end
            rnsc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    a_next   = quot;
                    sum_next = '0;
                    cnt_next = '0;
                end
            end
            rnsc_pkg::ST_EPS:
            begin
                s65     = {1'b0, a_reg} + {33'd0, epsilon};
                m_next  = s65[64] ? '1 : s65[63:0];
                lo_next = '0;
                hi_next = 32'h8000_0000;
                mid_next = 32'h8000_0000;   // first probe: the clip test
            end
            rnsc_pkg::ST_ROOT_SQ:
            begin
                sq_next = {32'd0, mid_reg} * {32'd0, mid_reg};
                t_next  = '0;
                k_next  = '0;
            end
            rnsc_pkg::ST_ROOT_MUL:
            begin
                // sq times m by 32 bit partial products, one per cycle
                mpart = k_reg[0] ? m_reg[63:32] : m_reg[31:0];
                pp    = (k_reg[1] ? {32'd0, sq_reg[63:32]} : {32'd0, sq_reg[31:0]})
                        * {32'd0, mpart};
                t_next = t_reg + ({64'd0, pp} << (7'(k_reg[0] + k_reg[1]) * 7'd32));
                k_next = k_reg + 2'd1;
            end
            rnsc_pkg::ST_ROOT_CMP:
            begin
                // fits when t <= 2^72
                if (mid_reg == 32'h8000_0000 && lo_reg == 32'd0 &&
                    hi_reg == 32'h8000_0000)
                begin
                    if (t_reg <= (128'd1 << 72))
                    begin
                        inv_next  = rnsc_pkg::InvRmsMax;
                        clip_next = 1'b1;
                        mid_next  = 32'd0;
                        hi_next   = 32'd1;
                    end
                    else
                    begin
                        mid_next = 32'h4000_0000;
                    end
                end
                else
                begin
                    if (t_reg <= (128'd1 << 72))
                    begin
                        lo_next  = mid_reg;
                    end
                    else
                    begin
                        hi_next  = mid_reg;
                    end
                    mid_next = (t_reg <= (128'd1 << 72)) ?
                        mid_reg + ((hi_reg - mid_reg) >> 1) :
                        lo_reg + ((mid_reg - lo_reg) >> 1);
                    if (((t_reg <= (128'd1 << 72)) ? hi_reg - mid_reg
                                                   : mid_reg - lo_reg) <= 32'd1)
                    begin
                        inv_next = (t_reg <= (128'd1 << 72)) ? mid_reg : lo_reg;
                    end
                end
            end
            rnsc_pkg::ST_NRM_P:
            begin
                a_next = {32'd0, job_reg.mag} * {32'd0, job_reg.wmag};
            end
            rnsc_pkg::ST_NRM_M0:
            begin
                t_next = {64'd0, {32'd0, a_reg[31:0]} * {32'd0, inv_reg}};
            end
            rnsc_pkg::ST_NRM_M1:
            begin
                t_next = t_reg + ({64'd0, {32'd0, a_reg[63:32]} * {32'd0, inv_reg}} << 32);
            end
            rnsc_pkg::ST_NRM_OUT:
            begin
                rnd = t_reg[100:36] + {64'd0, t_reg[35]};
                lim = job_reg.neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
                if (rnd > {32'd0, lim})
                begin
                    clip_o = 1'b1;
                    qv     = lim[31:0];
                end
                else
                begin
                    qv = rnd[31:0];
                end
                res_valid      = 1'b1;
                res.normalized = job_reg.neg ? 32'd0 - qv : qv;
                res.saturated  = clip_o | clip_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        m_reg   <= m_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        sq_reg  <= sq_next;
        t_reg   <= t_next;
        k_reg   <= k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= rnsc_pkg::ST_IDLE;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            inv_reg  <= rnsc_pkg::InvRmsReset;
            clip_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            inv_reg  <= inv_next;
            clip_reg <= clip_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 14'(MAX_LEN))
        else $error("element count beyond limit");
    a_res_from_norm: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(st_reg) == rnsc_pkg::ST_NRM_M1)
        else $error("result outside normalize sequence");
    a_div_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == rnsc_pkg::ST_EPS) |-> (sum_reg == '0 && cnt_reg == '0))
        else $error("accumulator not cleared after division");
endmodule

[rtl/rms_norm_scale_core.sv]
// ----------------------------------------------------------------------------
// rms_norm_scale_core: RMS normalisation with per-element weight
// Two-pass Q16.16 normaliser; inverse root kept in Q12.20.
// ----------------------------------------------------------------------------
//  channel   | signals                         | flow
//  ----------+---------------------------------+-------------------------------
//  request   | start, busy, req                | in, taken when start && !busy
//  result    | res_strobe, res                 | out, one cycle, no back-pressure
//  config    | cfg_valid, cfg_ready, cfg_data  | in, epsilon write, ready when idle
//
// An accumulate request squares and adds in the back end; the last one then
// runs the divider, adds epsilon and makes 32 root probes (square, partial
// products, compare), or a single probe when the inverse clips.
// A normalise request forms the weighted sample, scales it by the inverse root as a split 64x32 product and rounds.
// A two-entry queue sits between intake and sequencer; busy only when full.
// Reset clears the queue, accumulator, clip flag and sets inverse root to 1.0.
// The result strobe is never stalled: the receiver must take it.
module rms_norm_scale_core #(
    parameter int unsigned MAX_LEN = rnsc_pkg::MaxLenDefault
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  rnsc_pkg::req_t  req,
    output logic            res_strobe,
    output rnsc_pkg::res_t  res,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [31:0]     cfg_data
);
    logic [31:0]    eps_reg;
    logic           pop, job_valid, idle;
    rnsc_pkg::job_t job;

    // take epsilon only while nothing is queued or in the sequencer
    assign cfg_ready = idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= rnsc_pkg::EpsilonReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            eps_reg <= cfg_data;
        end
    end

    rnsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .pop       (pop),
        .job_valid (job_valid),
        .job       (job)
    );

    rnsc_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .epsilon   (eps_reg),
        .job_valid (job_valid),
        .job       (job),
        .pop       (pop),
        .idle      (idle),
        .res_valid (res_strobe),
        .res       (res)
    );

    a_idle_no_res: assert property (@(posedge clk) disable iff (!rst_n)
        idle |-> !res_strobe)
        else $error("result while idle");
    a_empty_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid |-> !busy)
        else $error("busy with empty queue");
    a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |=> !res_strobe)
        else $error("result strobe longer than one cycle");
endmodule

[dv/tb_rms_norm_scale_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rms_norm_scale_core: self-checking bench for the RMS normaliser core
// Drives accumulate and normalise requests, mirrors the two-pass arithmetic
// in a local predictor and checks every result strobe against it in order.
// ----------------------------------------------------------------------------
module tb_rms_norm_scale_core;

    localparam int unsigned MAX_LEN     = rnsc_pkg::MaxLenDefault;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    // a last accumulate runs the divider and root search with no result; leave margin
    localparam int unsigned SETTLE      = 400;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    rnsc_pkg::req_t req;
    logic       res_strobe;
    rnsc_pkg::res_t res;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [31:0] cfg_data;

    rms_norm_scale_core #(.MAX_LEN(MAX_LEN)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .res_strobe (res_strobe),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // predictor state: a private copy of the block's registers
    logic [31:0] mdl_epsilon;
    logic [63:0] mdl_sum;
    int unsigned mdl_count;
    logic [31:0] mdl_inv_rms;
    logic        mdl_clip;

    rnsc_pkg::res_t expected_results[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned requests_sent;
    int unsigned vectors_closed;
    int unsigned cycles = 0;
    int unsigned send_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // give up on a hang
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // true when r*r*m <= 2^72, i.e. r is no larger than 2^36 / sqrt(m)
    function automatic bit root_fits(logic [63:0] r, logic [63:0] m);
        logic [127:0] prod;
        logic [63:0]  rr;
        begin
            rr   = r * r;
            prod = {64'd0, rr} * {64'd0, m};
            return prod <= (128'd1 << 72);
        end
    endfunction

    // close the vector: mean square plus epsilon, then inverse root in Q12.20
    function automatic void close_vector();
        logic [63:0] n;
        logic [63:0] m;
        logic [64:0] m_eps;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        begin
            n     = (mdl_count != 0) ? 64'(mdl_count) : 64'd1;
            m     = mdl_sum / n;
            m_eps = {1'b0, m} + {33'd0, mdl_epsilon};
            m     = m_eps[64] ? '1 : m_eps[63:0];
            if (root_fits(64'h8000_0000, m))
            begin
                mdl_inv_rms = rnsc_pkg::InvRmsMax;
                mdl_clip    = 1'b1;
            end
            else
            begin
                lo = 0;
                hi = 64'h8000_0000;
                while (hi - lo > 1)
                begin
                    mid = lo + ((hi - lo) >> 1);
                    if (root_fits(mid, m))
                        lo = mid;
                    else
                        hi = mid;
                end
                mdl_inv_rms = lo[31:0];
            end
            mdl_sum   = 0;
            mdl_count = 0;
            vectors_closed++;
        end
    endfunction

    // advance the predictor by one request; queue a result for normalise
    function automatic void predict_rms(rnsc_pkg::req_t r);
        longint      x;
        longint      w;
        longint      p;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [64:0] acc;
        logic [63:0] pm;
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] limit;
        logic        neg;
        logic        clip;
        logic [31:0] val;
        rnsc_pkg::res_t e;
        begin
            x   = longint'(signed'(r.sample));
            mag = (x < 0) ? 64'(-x) : 64'(x);
            if (r.opcode == rnsc_pkg::OpAccumulate)
            begin
                sq = mag * mag;
                if (mdl_count == 0)
                    mdl_clip = 1'b0;
                acc = {1'b0, mdl_sum} + {1'b0, sq};
                if (acc[64])
                begin
                    mdl_sum  = '1;
                    mdl_clip = 1'b1;
                end
                else
                    mdl_sum = acc[63:0];
                if (mdl_count >= MAX_LEN)
                begin
                    mdl_count = MAX_LEN;
                    mdl_clip  = 1'b1;
                end
                else
                    mdl_count++;
                if (r.is_last)
                    close_vector();
            end
            else
            begin
                w     = r.weight_present ? longint'(signed'(r.weight)) : 65536;
                p     = x * w;
                neg   = p < 0;
                pm    = neg ? 64'(-p) : 64'(p);
                prod  = {64'd0, pm} * {96'd0, mdl_inv_rms} + (128'd1 << 35);
                q     = prod >> 36;
                limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                clip  = 1'b0;
                if (q > limit)
                begin
                    q    = limit;
                    clip = 1'b1;
                end
                val          = neg ? (32'd0 - q[31:0]) : q[31:0];
                e.normalized = val;
                e.saturated  = clip | mdl_clip;
                expected_results = {expected_results, e};
            end
        end
    endfunction

    // check each result against the oldest expectation
    always @(negedge clk)
    begin
        if (rst_n && res_strobe)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h/%b", res.normalized, res.saturated);
            end
            else
            begin
                rnsc_pkg::res_t e;
                e = expected_results.pop_front();
                if (res.normalized !== e.normalized || res.saturated !== e.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b got %h/%b",
                                 e.normalized, e.saturated, res.normalized, res.saturated);
                end
            end
        end
    end

    // hold the request until it is taken, then update the predictor
    task automatic send_request(rnsc_pkg::req_t r);
        begin
            req   <= r;
            start <= 1'b1;
            do
                @(negedge clk);
            while (busy);
            @(posedge clk);
            predict_rms(r);
            requests_sent++;
            if ($urandom_range(0, 99) < send_idle_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    endtask

    task automatic make_request(output rnsc_pkg::req_t r, input logic op,
                                input logic [31:0] s, input logic [31:0] w,
                                input logic wp, input logic last);
        begin
            r.opcode         = op;
            r.sample         = s;
            r.weight         = w;
            r.weight_present = wp;
            r.is_last        = last;
        end
    endtask

    task automatic drop_start();
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // wait for every result, then for the silent tail of a vector close
    task automatic drain_all();
        begin
            drop_start();
            while (expected_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    // write epsilon; only call when drained
    task automatic write_epsilon(logic [31:0] v);
        begin
            cfg_data  <= v;
            cfg_valid <= 1'b1;
            do
                @(negedge clk);
            while (!cfg_ready);
            @(posedge clk);
            cfg_valid   <= 1'b0;
            mdl_epsilon  = v;
            @(posedge clk);
        end
    endtask

    // biased sample: extremes, small values and full-range words
    function automatic logic [31:0] pick_word();
        begin
            case ($urandom_range(0, 6))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
                3: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                default: return $urandom;
            endcase
        end
    endfunction

    task automatic test_directed();
        rnsc_pkg::req_t r;
        begin
            // normalise before any accumulate: reset inverse of 1.0
            make_request(r, rnsc_pkg::OpNormalize, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b1);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0);
            send_request(r);
            // ordinary vector with extreme elements
            make_request(r, rnsc_pkg::OpAccumulate, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
            send_request(r);
            make_request(r, rnsc_pkg::OpAccumulate, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
            send_request(r);
            make_request(r, rnsc_pkg::OpAccumulate, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b1);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'h8000_0000, 32'h0001_0000, 1'b1, 1'b0);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
            send_request(r);
            // sum overflow: five squares of 2^62
            repeat (4)
            begin
                make_request(r, rnsc_pkg::OpAccumulate, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
                send_request(r);
            end
            make_request(r, rnsc_pkg::OpAccumulate, 32'h8000_0000, 32'h0, 1'b0, 1'b1);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'h0001_0000, 32'h0, 1'b0, 1'b0);
            send_request(r);
            // new vector clears the clip flag
            make_request(r, rnsc_pkg::OpAccumulate, 32'h0000_4000, 32'h0, 1'b0, 1'b1);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'h0000_4000, 32'h0002_0000, 1'b1, 1'b0);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'hFFFF_C000, 32'h0, 1'b0, 1'b0);
            send_request(r);
            drain_all();
        end
    endtask

    // zero vector with no epsilon: inverse clips at its maximum
    task automatic test_inverse_clip();
        rnsc_pkg::req_t r;
        begin
            write_epsilon(32'h0);
            make_request(r, rnsc_pkg::OpAccumulate, 32'h0, 32'h0, 1'b0, 1'b0);
            send_request(r);
            make_request(r, rnsc_pkg::OpAccumulate, 32'h0, 32'h0, 1'b0, 1'b1);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'h0000_0001, 32'h0, 1'b0, 1'b0);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'h0001_0000, 32'h0, 1'b0, 1'b0);
            send_request(r);
            // is_last on its own with nothing accumulated
            make_request(r, rnsc_pkg::OpAccumulate, 32'h0, 32'h0, 1'b0, 1'b1);
            send_request(r);
            make_request(r, rnsc_pkg::OpNormalize, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
            send_request(r);
            drain_all();
        end
    endtask

    // mostly well-formed vectors with random content, some noise
    task automatic test_random(int unsigned count);
        rnsc_pkg::req_t r;
        int unsigned sent;
        int unsigned len;
        int unsigned n_norm;
        int unsigned pause_at;
        begin
            sent     = 0;
            pause_at = $urandom_range(count / 4, count / 2);
            while (sent < count)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: fully random request
                    make_request(r, $urandom_range(0, 1), pick_word(), pick_word(),
                                 $urandom_range(0, 1), $urandom_range(0, 1));
                    send_request(r);
                    sent++;
                end
                else
                begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                                      : $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                    begin
                        make_request(r, rnsc_pkg::OpAccumulate, pick_word(), $urandom,
                                     $urandom_range(0, 1), i == len - 1);
                        send_request(r);
                    end
                    n_norm = $urandom_range(1, len + 2);
                    repeat (n_norm)
                    begin
                        make_request(r, rnsc_pkg::OpNormalize, pick_word(), pick_word(),
                                     $urandom_range(0, 3) != 0, $urandom_range(0, 1));
                        send_request(r);
                    end
                    sent += len + n_norm;
                end
                if (pause_at != 0 && sent >= pause_at)
                begin
                    // hold off until the block has delivered everything
                    pause_at = 0;
                    drop_start();
                    while (expected_results.size() != 0)
                        @(posedge clk);
                end
            end
            drain_all();
        end
    endtask

    initial
    begin
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        requests_sent  = 0;
        vectors_closed = 0;
        send_idle_pct  = 0;
        mdl_epsilon = rnsc_pkg::EpsilonReset;
        mdl_sum     = 0;
        mdl_count   = 0;
        mdl_inv_rms = rnsc_pkg::InvRmsReset;
        mdl_clip    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_inverse_clip();

        send_idle_pct = 17;
        write_epsilon($urandom);
        test_random(600);
        send_idle_pct = 85;
        write_epsilon(32'hFFFF_FFFF);
        test_random(600);
        send_idle_pct = 0;
        write_epsilon($urandom_range(0, 65535));
        test_random(600);

        repeat (50) @(posedge clk);
        mismatches += expected_results.size();
        $display("covered %0d requests, %0d vectors closed, %0d results checked",
                 requests_sent, vectors_closed, results_seen);
        $display("epsilon swept from zero to full scale; sender idle 17%%, 85%% and 0%%");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
